// ===== hdl/tmram_pkg.sv =====
// Shared types, codes and small arithmetic helpers for the ternary cell array.
`timescale 1ns / 1ps
package tmram_pkg;

	localparam int STATE_W = 2;
	localparam int RES_W   = 16;
	localparam int WORD_W  = STATE_W + RES_W;
	localparam int TOTAL_W = 12;
	localparam int COUNT_W = 11;

	// request actions
	localparam logic [2:0] ACT_WRITE_TRIT  = 3'd0;
	localparam logic [2:0] ACT_READ_TRIT   = 3'd1;
	localparam logic [2:0] ACT_WRITE_PACK  = 3'd2;
	localparam logic [2:0] ACT_READ_PACK   = 3'd3;
	localparam logic [2:0] ACT_XOR         = 3'd4;
	localparam logic [2:0] ACT_STABILIZE   = 3'd5;
	localparam logic [2:0] ACT_SCRUB       = 3'd6;
	localparam logic [2:0] ACT_INJECT      = 3'd7;

	// configuration register indexes
	localparam logic [2:0] REG_ROWS        = 3'd0;
	localparam logic [2:0] REG_COLS        = 3'd1;
	localparam logic [2:0] REG_RES_LOW     = 3'd2;
	localparam logic [2:0] REG_RES_MID     = 3'd3;
	localparam logic [2:0] REG_RES_HIGH    = 3'd4;
	localparam logic [2:0] REG_DRIFT_LIMIT = 3'd5;
	localparam logic [2:0] REG_RECAL_LIMIT = 3'd6;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_SCRUB = 2'd2;

	localparam logic [1:0] HEALTH_STABLE = 2'd0;
	localparam logic [1:0] HEALTH_RECAL  = 2'd1;
	localparam logic [1:0] HEALTH_FAILED = 2'd2;

	localparam logic [15:0] RES_LOW_RST     = 16'd50;
	localparam logic [15:0] RES_MID_RST     = 16'd100;
	localparam logic [15:0] RES_HIGH_RST    = 16'd150;
	localparam logic [15:0] DRIFT_LIMIT_RST = 16'd10;
	localparam logic [10:0] RECAL_LIMIT_RST = 11'd16;
	localparam logic [5:0]  DIM_RST         = 6'd32;
	localparam logic [10:0] RECAL_MAX       = 11'd2047;
	localparam logic [7:0]  PACK_MOD        = 8'd243;
	localparam logic [2:0]  TRITS_PER_BYTE  = 3'd5;

	typedef struct packed {
		logic [15:0] res_low;
		logic [15:0] res_mid;
		logic [15:0] res_high;
		logic [15:0] drift_limit;
	} cell_cfg_t;

	typedef struct packed {
		logic        we;
		logic [1:0]  wstate;
		logic [15:0] wres;
		logic [1:0]  sense;
		logic        mismatch;
		logic        hit;
	} cell_res_t;

	// two's complement trit field to cell state, modulo 3
	function automatic logic [1:0] trit_to_state(input logic [1:0] t);
		logic [1:0] s;
		unique case (t)
			2'd0: s = 2'd1;
			2'd1: s = 2'd2;
			2'd2: s = 2'd2;
			default: s = 2'd0;
		endcase
		return s;
	endfunction

	// cell state to two's complement trit
	function automatic logic [1:0] state_to_trit(input logic [1:0] s);
		logic [1:0] t;
		unique case (s)
			2'd0: t = 2'd3;
			2'd1: t = 2'd0;
			2'd2: t = 2'd1;
			default: t = 2'd2;
		endcase
		return t;
	endfunction

	// (a + b + 2) mod 3 for states
	function automatic logic [1:0] xor_state(input logic [1:0] a, input logic [1:0] b);
		logic [2:0] s;
		logic [1:0] m;
		s = {1'b0, a} + {1'b0, b};
		unique case (s)
			3'd0, 3'd3, 3'd6: m = 2'd2;
			3'd1, 3'd4:       m = 2'd0;
			default:          m = 2'd1;
		endcase
		return m;
	endfunction

	// v / 3 for 8-bit v by reciprocal multiply
	function automatic logic [7:0] div3(input logic [7:0] v);
		logic [15:0] p;
		p = {8'd0, v} * 16'd171;
		return {1'b0, p[15:9]};
	endfunction

	// weight of trit k in a packed byte
	function automatic logic [7:0] pow3(input logic [2:0] k);
		logic [7:0] w;
		unique case (k)
			3'd0: w = 8'd1;
			3'd1: w = 8'd3;
			3'd2: w = 8'd9;
			3'd3: w = 8'd27;
			3'd4: w = 8'd81;
			default: w = 8'd0;
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/tmram_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module tmram_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/tmram_cell_alu.sv =====
// Per-cell sense and modify logic for one memory word.
`timescale 1ns / 1ps
module tmram_cell_alu (
	input  logic [2:0]                  op,
	input  logic [tmram_pkg::WORD_W-1:0] word,
	input  tmram_pkg::cell_cfg_t        cfg,
	input  logic [1:0]                  tstate,
	input  logic [1:0]                  digit,
	input  logic signed [15:0]          drift,
	output tmram_pkg::cell_res_t        res
);
	logic [1:0]         st;
	logic [15:0]        r;
	logic [16:0]        thr0, thr1;
	logic [1:0]         sense;
	logic [15:0]        nom_st;
	logic [15:0]        diff;
	logic signed [17:0] sum;
	logic [15:0]        sat;
	logic [1:0]         xs;

	function automatic logic [15:0] nom_of(input logic [1:0] s, input tmram_pkg::cell_cfg_t c);
		logic [15:0] n;
		if (s == 2'd0) begin
			n = c.res_low;
		end else if (s == 2'd2) begin
			n = c.res_high;
		end else begin
			n = c.res_mid;
		end
		return n;
	endfunction

	assign st = word[tmram_pkg::WORD_W-1:tmram_pkg::RES_W];
	assign r  = word[tmram_pkg::RES_W-1:0];

	// sense against midpoints of nominal levels
	always_comb begin
		thr0 = ({1'b0, cfg.res_low} + {1'b0, cfg.res_mid}) >> 1;
		thr1 = ({1'b0, cfg.res_mid} + {1'b0, cfg.res_high}) >> 1;
		if ({1'b0, r} < thr0) begin
			sense = 2'd0;
		end else if ({1'b0, r} < thr1) begin
			sense = 2'd1;
		end else begin
			sense = 2'd2;
		end
	end

	assign nom_st = nom_of(st, cfg);
	assign diff   = (r > nom_st) ? (r - nom_st) : (nom_st - r);
	assign xs     = tmram_pkg::xor_state(st, tstate);

	// saturating drift injection
	always_comb begin
		sum = $signed({2'b00, r}) + $signed({{2{drift[15]}}, drift});
		if (sum < 0) begin
			sat = 16'd0;
		end else if (sum > 18'sd65535) begin
			sat = 16'hFFFF;
		end else begin
			sat = sum[15:0];
		end
	end

	// modify by action
	always_comb begin
		res          = '0;
		res.sense    = sense;
		res.mismatch = (sense != st);
		res.wstate   = st;
		res.wres     = nom_st;
		unique case (op)
			tmram_pkg::ACT_WRITE_TRIT: begin
				res.we     = 1'b1;
				res.wstate = tstate;
				res.wres   = nom_of(tstate, cfg);
			end
			tmram_pkg::ACT_WRITE_PACK: begin
				res.we     = 1'b1;
				res.wstate = digit;
				res.wres   = nom_of(digit, cfg);
			end
			tmram_pkg::ACT_XOR: begin
				res.we     = 1'b1;
				res.wstate = xs;
				res.wres   = nom_of(xs, cfg);
			end
			tmram_pkg::ACT_STABILIZE: begin
				res.hit = (r != nom_st);
				res.we  = (r != nom_st);
			end
			tmram_pkg::ACT_SCRUB: begin
				res.hit = (diff > cfg.drift_limit) && (sense != st);
				res.we  = (diff > cfg.drift_limit) && (sense != st);
			end
			tmram_pkg::ACT_INJECT: begin
				res.we   = 1'b1;
				res.wres = sat;
			end
			default: begin
				res.we = 1'b0;
			end
		endcase
	end
endmodule

// ===== hdl/ternary_mram_array_with_scrub_top.sv =====
// Ternary resistance cell array: request sequencer around the cell memory.
//
//  channel   direction  handshake             payload
//  in        to block   in_valid / in_stall   action row col address all_cells
//                                             trit_value byte_value drift_amount
//  out       from block out_valid / out_stall status read_trit packed_byte
//                                             drift_seen cell_count trits_moved health
//  cfg       to block   cfg_we                cfg_index cfg_data
//
// One request at a time. A request walks its cells with one read-modify-write
// of the cell memory per cycle (trit and single-cell accesses one cell, packed
// accesses five, scrub and full stabilize rows*cols); out-of-range requests
// walk no cells.
// After reset a clearing pass writes all MAX_ROWS*MAX_COLS cells, one per
// cycle, with in_stall high. A stalled result holds until taken.
`timescale 1ns / 1ps
module ternary_mram_array_with_scrub_top #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [4:0]         row,
	input  logic [4:0]         col,
	input  logic [9:0]         address,
	input  logic               all_cells,
	input  logic signed [1:0]  trit_value,
	input  logic [7:0]         byte_value,
	input  logic signed [15:0] drift_amount,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [1:0]  read_trit,
	output logic [7:0]         packed_byte,
	output logic               drift_seen,
	output logic [10:0]        cell_count,
	output logic [2:0]         trits_moved,
	output logic [1:0]         health,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int TW    = tmram_pkg::TOTAL_W;
	localparam logic [8:0] ROWS_CAP = 9'(MAX_ROWS);
	localparam logic [8:0] COLS_CAP = 9'(MAX_COLS);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]  state_q;
	logic [5:0]  rows_q, cols_q;
	logic [15:0] res_low_q, res_mid_q, res_high_q, drift_limit_q;
	logic [10:0] recal_limit_q;
	logic [10:0] recal_q;
	logic [1:0]  health_q;

	logic [AW-1:0] idx_q;
	logic [TW-1:0] left_q;
	logic [2:0]    k_q;
	logic          rv_s1, last_s1;
	logic [AW-1:0] ra_s1;
	logic [2:0]    rk_s1;

	logic [2:0]         op_q;
	logic [1:0]         ts_q;
	logic [7:0]         v_q;
	logic signed [15:0] drift_q;
	logic [1:0]         status_q;
	logic [1:0]         rtrit_q;
	logic [7:0]         packed_q;
	logic               seen_q;
	logic [10:0]        count_q;
	logic [2:0]         moved_q;

	logic [5:0]    er, ec;
	logic [TW-1:0] total, flat, start, n;
	logic          bad;
	logic          accept;

	logic                         ram_we, ram_re;
	logic [AW-1:0]                ram_waddr, ram_raddr;
	logic [tmram_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

	tmram_pkg::cell_cfg_t cfg;
	tmram_pkg::cell_res_t alu;
	logic [7:0]           q3;
	logic [1:0]           digit;
	logic [7:0]           pk_term;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q        <= tmram_pkg::DIM_RST;
			cols_q        <= tmram_pkg::DIM_RST;
			res_low_q     <= tmram_pkg::RES_LOW_RST;
			res_mid_q     <= tmram_pkg::RES_MID_RST;
			res_high_q    <= tmram_pkg::RES_HIGH_RST;
			drift_limit_q <= tmram_pkg::DRIFT_LIMIT_RST;
			recal_limit_q <= tmram_pkg::RECAL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tmram_pkg::REG_ROWS:        rows_q        <= cfg_data[5:0];
				tmram_pkg::REG_COLS:        cols_q        <= cfg_data[5:0];
				tmram_pkg::REG_RES_LOW:     res_low_q     <= cfg_data;
				tmram_pkg::REG_RES_MID:     res_mid_q     <= cfg_data;
				tmram_pkg::REG_RES_HIGH:    res_high_q    <= cfg_data;
				tmram_pkg::REG_DRIFT_LIMIT: drift_limit_q <= cfg_data;
				tmram_pkg::REG_RECAL_LIMIT: recal_limit_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign cfg = '{res_low: res_low_q, res_mid: res_mid_q, res_high: res_high_q,
		drift_limit: drift_limit_q};

	// active size and request decode
	always_comb begin
		er    = ({3'b0, rows_q} > ROWS_CAP) ? ROWS_CAP[5:0] : rows_q;
		ec    = ({3'b0, cols_q} > COLS_CAP) ? COLS_CAP[5:0] : cols_q;
		total = {6'b0, er} * {6'b0, ec};
		flat  = {7'b0, row} * {6'b0, ec} + {7'b0, col};
		bad   = 1'b0;
		start = {2'b0, address};
		n     = TW'(1);
		unique case (action)
			tmram_pkg::ACT_WRITE_TRIT, tmram_pkg::ACT_READ_TRIT: begin
				bad   = ({1'b0, row} >= er) || ({1'b0, col} >= ec);
				start = flat;
			end
			tmram_pkg::ACT_WRITE_PACK, tmram_pkg::ACT_READ_PACK: begin
				bad = ({2'b0, address} + TW'(tmram_pkg::TRITS_PER_BYTE)) > total;
				n   = TW'(tmram_pkg::TRITS_PER_BYTE);
			end
			tmram_pkg::ACT_STABILIZE: begin
				if (all_cells) begin
					start = '0;
					n     = total;
				end else if ({2'b0, address} >= total) begin
					n = '0;
				end
			end
			tmram_pkg::ACT_SCRUB: begin
				start = '0;
				n     = total;
			end
			default: begin
				bad = ({2'b0, address} >= total);
			end
		endcase
		if (bad) begin
			n = '0;
		end
	end

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// cell memory
	assign ram_re    = (state_q == ST_RUN) && (left_q != '0);
	assign ram_raddr = idx_q;
	assign ram_we    = (state_q == ST_CLEAR) || (rv_s1 && alu.we);
	assign ram_waddr = (state_q == ST_CLEAR) ? idx_q : ra_s1;
	assign ram_wdata = (state_q == ST_CLEAR) ? {2'b00, tmram_pkg::RES_LOW_RST}
		: {alu.wstate, alu.wres};

	tmram_ram #(.WIDTH(tmram_pkg::WORD_W), .DEPTH(CELLS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// packed digit peel
	assign q3      = tmram_pkg::div3(v_q);
	assign digit   = 2'(v_q - {q3[6:0], 1'b0} - q3);
	assign pk_term = {6'b0, alu.sense} * tmram_pkg::pow3(rk_s1);

	tmram_cell_alu u_alu (
		.op     (op_q),
		.word   (ram_rdata),
		.cfg    (cfg),
		.tstate (ts_q),
		.digit  (digit),
		.drift  (drift_q),
		.res    (alu)
	);

	// sequencer and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			idx_q    <= '0;
			left_q   <= '0;
			k_q      <= '0;
			rv_s1    <= 1'b0;
			last_s1  <= 1'b0;
			ra_s1    <= '0;
			rk_s1    <= '0;
			recal_q  <= '0;
			health_q <= tmram_pkg::HEALTH_STABLE;
		end else begin
			rv_s1 <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= AW'(start);
						left_q  <= n;
						k_q     <= '0;
						state_q <= (n == '0) ? ST_FIN : ST_RUN;
					end
				end
				ST_RUN: begin
					if (left_q != '0) begin
						idx_q   <= idx_q + AW'(1);
						left_q  <= left_q - TW'(1);
						k_q     <= k_q + 3'd1;
						rv_s1   <= 1'b1;
						ra_s1   <= idx_q;
						rk_s1   <= k_q;
						last_s1 <= (left_q == TW'(1));
					end
					if (rv_s1 && last_s1) begin
						state_q <= ST_FIN;
					end
					if (rv_s1 && alu.hit && op_q == tmram_pkg::ACT_SCRUB
							&& recal_q != tmram_pkg::RECAL_MAX) begin
						recal_q <= recal_q + 11'd1;
					end
				end
				ST_FIN: begin
					state_q <= ST_OUT;
					if (op_q == tmram_pkg::ACT_STABILIZE) begin
						health_q <= tmram_pkg::HEALTH_STABLE;
						recal_q  <= '0;
					end else if (op_q == tmram_pkg::ACT_SCRUB) begin
						if (recal_q > recal_limit_q) begin
							health_q <= tmram_pkg::HEALTH_FAILED;
						end else begin
							health_q <= (count_q != '0) ? tmram_pkg::HEALTH_RECAL
								: tmram_pkg::HEALTH_STABLE;
						end
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request context and result accumulation
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= action;
			ts_q     <= tmram_pkg::trit_to_state(trit_value);
			v_q      <= (byte_value >= tmram_pkg::PACK_MOD) ?
				(byte_value - tmram_pkg::PACK_MOD) : byte_value;
			drift_q  <= drift_amount;
			status_q <= (bad && action != tmram_pkg::ACT_STABILIZE
				&& action != tmram_pkg::ACT_SCRUB) ? tmram_pkg::STATUS_RANGE
				: tmram_pkg::STATUS_OK;
			rtrit_q  <= '0;
			packed_q <= '0;
			seen_q   <= 1'b0;
			count_q  <= '0;
			moved_q  <= (!bad && (action == tmram_pkg::ACT_WRITE_PACK
				|| action == tmram_pkg::ACT_READ_PACK)) ? tmram_pkg::TRITS_PER_BYTE : 3'd0;
		end else if (state_q == ST_FIN) begin
			if (op_q == tmram_pkg::ACT_SCRUB && recal_q > recal_limit_q) begin
				status_q <= tmram_pkg::STATUS_SCRUB;
			end
		end else if (rv_s1) begin
			unique case (op_q)
				tmram_pkg::ACT_READ_TRIT: begin
					rtrit_q <= tmram_pkg::state_to_trit(alu.sense);
				end
				tmram_pkg::ACT_READ_PACK: begin
					packed_q <= packed_q + pk_term;
					seen_q   <= seen_q | alu.mismatch;
				end
				tmram_pkg::ACT_WRITE_PACK: begin
					v_q <= q3;
				end
				tmram_pkg::ACT_STABILIZE, tmram_pkg::ACT_SCRUB: begin
					if (alu.hit) begin
						count_q <= count_q + 11'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// result port
	assign out_valid   = (state_q == ST_OUT);
	assign status      = status_q;
	assign read_trit   = rtrit_q;
	assign packed_byte = packed_q;
	assign drift_seen  = seen_q;
	assign cell_count  = count_q;
	assign trits_moved = moved_q;
	assign health      = health_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN || state_q == ST_FIN))
		else $error("accepted request did not start");
	a_rw_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("read and write hit the same cell");
	a_walk_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> (state_q == ST_RUN))
		else $error("cell data returned outside a walk");
	a_scrub_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == tmram_pkg::STATUS_SCRUB)
			|-> (health == tmram_pkg::HEALTH_FAILED))
		else $error("scrub failure without failed health");
	a_packed_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (packed_byte <= 8'd242))
		else $error("packed byte out of range");
`endif
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the ternary cell array with drift scrub.
`timescale 1ns / 1ps
module testbench;

	// one request and one result, at the port widths
	typedef struct packed {
		logic [2:0]  action;
		logic [4:0]  row;
		logic [4:0]  col;
		logic [9:0]  address;
		logic        all_cells;
		logic [1:0]  trit_value;
		logic [7:0]  byte_value;
		logic [15:0] drift_amount;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  read_trit;
		logic [7:0]  packed_byte;
		logic        drift_seen;
		logic [10:0] cell_count;
		logic [2:0]  trits_moved;
		logic [1:0]  health;
	} outcome_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		outcome_t res;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] action = '0;
	logic [4:0] row = '0;
	logic [4:0] col = '0;
	logic [9:0] address = '0;
	logic all_cells = 1'b0;
	logic signed [1:0] trit_value = '0;
	logic [7:0] byte_value = '0;
	logic signed [15:0] drift_amount = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic signed [1:0] read_trit;
	logic [7:0] packed_byte;
	logic drift_seen;
	logic [10:0] cell_count;
	logic [2:0] trits_moved;
	logic [1:0] health;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	ternary_mram_array_with_scrub_top dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("ternary_mram_array_with_scrub_top verification failed");
		$finish;
	end

	// shadow copy of the array and its registers
	logic [1:0]  cell_st [0:1023];
	logic [15:0] cell_res [0:1023];
	logic [5:0]  m_rows, m_cols;
	logic [15:0] m_low, m_mid, m_high, m_drift_lim;
	logic [10:0] m_recal_lim, m_recal_total;
	logic [1:0]  m_health;

	outcome_t pending_results [$];
	int errors = 0;
	int taken = 0;
	int scrub_fails = 0;
	int per_action [8];
	int in_pct = 0, out_pct = 0;
	int hold_len = 0;

	function automatic int eff_rows();
		return m_rows > 32 ? 32 : int'(m_rows);
	endfunction

	function automatic int eff_cols();
		return m_cols > 32 ? 32 : int'(m_cols);
	endfunction

	function automatic int nominal_res(input logic [1:0] s);
		if (s == 2'd0) return int'(m_low);
		if (s == 2'd2) return int'(m_high);
		return int'(m_mid);
	endfunction

	function automatic logic [1:0] sensed_state(input int idx);
		int r;
		r = int'(cell_res[idx]);
		if (r < (int'(m_low) + int'(m_mid)) / 2) return 2'd0;
		if (r < (int'(m_mid) + int'(m_high)) / 2) return 2'd1;
		return 2'd2;
	endfunction

	function automatic logic [1:0] trit_state(input logic [1:0] t);
		int v;
		v = int'($signed(t));
		return 2'((v + 4) % 3);
	endfunction

	function automatic void store_cell(input int idx, input logic [1:0] s);
		cell_st[idx] = s;
		cell_res[idx] = 16'(nominal_res(s));
	endfunction

	function automatic void shadow_reset();
		m_rows = tmram_pkg::DIM_RST;
		m_cols = tmram_pkg::DIM_RST;
		m_low = tmram_pkg::RES_LOW_RST;
		m_mid = tmram_pkg::RES_MID_RST;
		m_high = tmram_pkg::RES_HIGH_RST;
		m_drift_lim = tmram_pkg::DRIFT_LIMIT_RST;
		m_recal_lim = tmram_pkg::RECAL_LIMIT_RST;
		m_recal_total = '0;
		m_health = tmram_pkg::HEALTH_STABLE;
		for (int i = 0; i < 1024; i++) begin
			cell_st[i] = 2'd0;
			cell_res[i] = tmram_pkg::RES_LOW_RST;
		end
	endfunction

	// apply one request to the shadow array and return its result
	function automatic outcome_t array_outcome(input request_t q);
		outcome_t o;
		int tot, idx, v, w, r, d, nom;
		logic [1:0] s;
		o = '0;
		tot = eff_rows() * eff_cols();
		case (q.action)
			tmram_pkg::ACT_WRITE_TRIT, tmram_pkg::ACT_READ_TRIT: begin
				if (q.row >= eff_rows() || q.col >= eff_cols()) begin
					o.status = tmram_pkg::STATUS_RANGE;
				end else begin
					idx = q.row * eff_cols() + q.col;
					if (q.action == tmram_pkg::ACT_WRITE_TRIT)
						store_cell(idx, trit_state(q.trit_value));
					else o.read_trit = sensed_state(idx) - 2'd1;
				end
			end
			tmram_pkg::ACT_WRITE_PACK, tmram_pkg::ACT_READ_PACK: begin
				if (q.address + 5 > tot) begin
					o.status = tmram_pkg::STATUS_RANGE;
				end else begin
					v = q.byte_value % 243;
					w = 1;
					for (int k = 0; k < 5; k++) begin
						if (q.action == tmram_pkg::ACT_WRITE_PACK) begin
							store_cell(q.address + k, 2'(v % 3));
							v = v / 3;
						end else begin
							s = sensed_state(q.address + k);
							if (s != cell_st[q.address + k]) o.drift_seen = 1'b1;
							o.packed_byte = o.packed_byte + 8'(s * w);
							w = w * 3;
						end
					end
					o.trits_moved = tmram_pkg::TRITS_PER_BYTE;
				end
			end
			tmram_pkg::ACT_XOR: begin
				if (q.address >= tot) o.status = tmram_pkg::STATUS_RANGE;
				else store_cell(q.address,
					2'((cell_st[q.address] + trit_state(q.trit_value) + 2) % 3));
			end
			tmram_pkg::ACT_STABILIZE: begin
				for (int i = q.all_cells ? 0 : q.address;
						i < (q.all_cells ? tot : q.address + 1) && i < tot; i++) begin
					nom = nominal_res(cell_st[i]);
					if (cell_res[i] != nom) begin
						cell_res[i] = 16'(nom);
						o.cell_count++;
					end
				end
				m_health = tmram_pkg::HEALTH_STABLE;
				m_recal_total = '0;
			end
			tmram_pkg::ACT_SCRUB: begin
				for (int i = 0; i < tot; i++) begin
					nom = nominal_res(cell_st[i]);
					r = int'(cell_res[i]);
					d = r > nom ? r - nom : nom - r;
					if (d > m_drift_lim && sensed_state(i) != cell_st[i]) begin
						cell_res[i] = 16'(nom);
						o.cell_count++;
						if (m_recal_total < tmram_pkg::RECAL_MAX) m_recal_total++;
					end
				end
				if (m_recal_total > m_recal_lim) begin
					m_health = tmram_pkg::HEALTH_FAILED;
					o.status = tmram_pkg::STATUS_SCRUB;
				end else begin
					m_health = o.cell_count > 0 ? tmram_pkg::HEALTH_RECAL
						: tmram_pkg::HEALTH_STABLE;
				end
			end
			default: begin
				if (q.address >= tot) begin
					o.status = tmram_pkg::STATUS_RANGE;
				end else begin
					r = int'(cell_res[q.address]) + int'($signed(q.drift_amount));
					if (r < 0) r = 0;
					if (r > 65535) r = 65535;
					cell_res[q.address] = 16'(r);
				end
			end
		endcase
		o.health = m_health;
		return o;
	endfunction

	// offer one request, wait for acceptance, then record what it must give
	task automatic offer(input request_t q, input logic typed, input outcome_t given);
		outcome_t o;
		while ($urandom_range(0, 99) < in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		action <= q.action;
		row <= q.row;
		col <= q.col;
		address <= q.address;
		all_cells <= q.all_cells;
		trit_value <= q.trit_value;
		byte_value <= q.byte_value;
		drift_amount <= q.drift_amount;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		o = array_outcome(q);
		pending_results.push_back(typed ? given : o);
		per_action[q.action]++;
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tmram_pkg::REG_ROWS: m_rows = val[5:0];
			tmram_pkg::REG_COLS: m_cols = val[5:0];
			tmram_pkg::REG_RES_LOW: m_low = val;
			tmram_pkg::REG_RES_MID: m_mid = val;
			tmram_pkg::REG_RES_HIGH: m_high = val;
			tmram_pkg::REG_DRIFT_LIMIT: m_drift_lim = val;
			default: m_recal_lim = val[10:0];
		endcase
		@(posedge clk);
	endtask

	// let every result drain before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(input int rr, input int cc, input int lo, input int mid,
			input int hi, input int dl, input int rl);
		drain();
		reg_write(tmram_pkg::REG_ROWS, 16'(rr));
		reg_write(tmram_pkg::REG_COLS, 16'(cc));
		reg_write(tmram_pkg::REG_RES_LOW, 16'(lo));
		reg_write(tmram_pkg::REG_RES_MID, 16'(mid));
		reg_write(tmram_pkg::REG_RES_HIGH, 16'(hi));
		reg_write(tmram_pkg::REG_DRIFT_LIMIT, 16'(dl));
		reg_write(tmram_pkg::REG_RECAL_LIMIT, 16'(rl));
	endtask

	// mostly in-range requests, some out of range, a few pure noise
	function automatic request_t random_request();
		request_t q;
		int sel, tot;
		tot = eff_rows() * eff_cols();
		q.row = 5'($urandom);
		q.col = 5'($urandom);
		q.address = 10'($urandom);
		q.all_cells = $urandom_range(0, 5) == 0;
		q.trit_value = 2'($urandom);
		q.byte_value = 8'($urandom);
		q.drift_amount = $urandom_range(0, 1) ? 16'($urandom_range(0, 120) - 60)
			: 16'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 14) q.action = tmram_pkg::ACT_WRITE_TRIT;
		else if (sel < 28) q.action = tmram_pkg::ACT_READ_TRIT;
		else if (sel < 40) q.action = tmram_pkg::ACT_WRITE_PACK;
		else if (sel < 54) q.action = tmram_pkg::ACT_READ_PACK;
		else if (sel < 64) q.action = tmram_pkg::ACT_XOR;
		else if (sel < 80) q.action = tmram_pkg::ACT_INJECT;
		else if (sel < 88) q.action = tmram_pkg::ACT_STABILIZE;
		else if (sel < 93) q.action = tmram_pkg::ACT_SCRUB;
		else return request_t'({$urandom, 18'($urandom)});
		if ($urandom_range(0, 9) != 0 && tot > 0) begin
			q.row = 5'($urandom_range(0, eff_rows() - 1));
			q.col = 5'($urandom_range(0, eff_cols() - 1));
			if (q.action == tmram_pkg::ACT_WRITE_PACK || q.action == tmram_pkg::ACT_READ_PACK)
				q.address = tot >= 5 ? 10'($urandom_range(0, tot - 5)) : 10'd0;
			else
				q.address = 10'($urandom_range(0, tot - 1));
		end
		return q;
	endfunction

	task automatic random_run(input int n, input int ip, input int op);
		in_pct = ip;
		out_pct = op;
		for (int i = 0; i < n; i++) offer(random_request(), 1'b0, '0);
	endtask

	// long receiver hold-off, counted down one cycle at a time
	always @(posedge clk) begin
		if (hold_len > 0) hold_len--;
	end

	// result channel: check each taken result, then choose the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			outcome_t got, want;
			got = '{status, read_trit, packed_byte, drift_seen, cell_count, trits_moved, health};
			taken++;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.status == tmram_pkg::STATUS_SCRUB) scrub_fails++;
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
				if (got.read_trit !== want.read_trit) begin
					$error("read_trit: expected %0d, got %0d",
						$signed(want.read_trit), $signed(got.read_trit));
					errors++;
				end
				if (got.packed_byte !== want.packed_byte) begin
					$error("packed_byte: expected %0d, got %0d", want.packed_byte, got.packed_byte);
					errors++;
				end
				if (got.drift_seen !== want.drift_seen) begin
					$error("drift_seen: expected %0d, got %0d", want.drift_seen, got.drift_seen);
					errors++;
				end
				if (got.cell_count !== want.cell_count) begin
					$error("cell_count: expected %0d, got %0d", want.cell_count, got.cell_count);
					errors++;
				end
				if (got.trits_moved !== want.trits_moved) begin
					$error("trits_moved: expected %0d, got %0d", want.trits_moved, got.trits_moved);
					errors++;
				end
				if (got.health !== want.health) begin
					$error("health: expected %0d, got %0d", want.health, got.health);
					errors++;
				end
			end
		end
		out_stall <= (hold_len > 0) || ($urandom_range(0, 99) < out_pct);
	end

	localparam outcome_t OK_RES = '0;
	localparam outcome_t RANGE_RES = '{tmram_pkg::STATUS_RANGE, 2'd0, 8'd0, 1'b0, 11'd0,
		3'd0, tmram_pkg::HEALTH_STABLE};
	localparam outcome_t PACK_OK = '{tmram_pkg::STATUS_OK, 2'd0, 8'd0, 1'b0, 11'd0, 3'd5,
		tmram_pkg::HEALTH_STABLE};

	// directed requests at the reset setting; typed results where obvious
	step_row_t directed [0:21] = '{
		'{'{tmram_pkg::ACT_READ_TRIT, 5'd0, 5'd0, 10'd0, 1'b0, 2'b00, 8'd0, 16'd0}, 1'b1,
			'{tmram_pkg::STATUS_OK, 2'b11, 8'd0, 1'b0, 11'd0, 3'd0,
				tmram_pkg::HEALTH_STABLE}},
		'{'{tmram_pkg::ACT_WRITE_TRIT, 5'd31, 5'd31, 10'd0, 1'b0, 2'b01, 8'd0, 16'd0}, 1'b1,
			OK_RES},
		'{'{tmram_pkg::ACT_READ_TRIT, 5'd31, 5'd31, 10'd0, 1'b0, 2'b00, 8'd0, 16'd0}, 1'b1,
			'{tmram_pkg::STATUS_OK, 2'b01, 8'd0, 1'b0, 11'd0, 3'd0,
				tmram_pkg::HEALTH_STABLE}},
		// minus two acts as plus one
		'{'{tmram_pkg::ACT_WRITE_TRIT, 5'd0, 5'd1, 10'd0, 1'b0, 2'b10, 8'd0, 16'd0}, 1'b1,
			OK_RES},
		'{'{tmram_pkg::ACT_READ_TRIT, 5'd0, 5'd1, 10'd0, 1'b0, 2'b00, 8'd0, 16'd0}, 1'b1,
			'{tmram_pkg::STATUS_OK, 2'b01, 8'd0, 1'b0, 11'd0, 3'd0,
				tmram_pkg::HEALTH_STABLE}},
		// byte 255 wraps to 12
		'{'{tmram_pkg::ACT_WRITE_PACK, 5'd0, 5'd0, 10'd1019, 1'b0, 2'b00, 8'd255, 16'd0},
			1'b1, PACK_OK},
		'{'{tmram_pkg::ACT_READ_PACK, 5'd0, 5'd0, 10'd1019, 1'b0, 2'b00, 8'd0, 16'd0}, 1'b1,
			'{tmram_pkg::STATUS_OK, 2'd0, 8'd12, 1'b0, 11'd0, 3'd5,
				tmram_pkg::HEALTH_STABLE}},
		'{'{tmram_pkg::ACT_WRITE_PACK, 5'd0, 5'd0, 10'd1020, 1'b0, 2'b00, 8'd7, 16'd0},
			1'b1, RANGE_RES},
		'{'{tmram_pkg::ACT_WRITE_PACK, 5'd0, 5'd0, 10'd0, 1'b0, 2'b00, 8'd242, 16'd0},
			1'b0, OK_RES},
		'{'{tmram_pkg::ACT_READ_PACK, 5'd0, 5'd0, 10'd0, 1'b0, 2'b00, 8'd0, 16'd0}, 1'b0,
			OK_RES},
		'{'{tmram_pkg::ACT_XOR, 5'd0, 5'd0, 10'd1023, 1'b0, 2'b01, 8'd0, 16'd0}, 1'b0,
			OK_RES},
		'{'{tmram_pkg::ACT_XOR, 5'd0, 5'd0, 10'd1023, 1'b0, 2'b11, 8'd0, 16'd0}, 1'b0,
			OK_RES},
		// saturation at both ends
		'{'{tmram_pkg::ACT_INJECT, 5'd0, 5'd0, 10'd5, 1'b0, 2'b00, 8'd0, 16'h7fff}, 1'b1,
			OK_RES},
		'{'{tmram_pkg::ACT_INJECT, 5'd0, 5'd0, 10'd5, 1'b0, 2'b00, 8'd0, 16'h7fff}, 1'b1,
			OK_RES},
		'{'{tmram_pkg::ACT_READ_TRIT, 5'd0, 5'd5, 10'd0, 1'b0, 2'b00, 8'd0, 16'd0}, 1'b1,
			'{tmram_pkg::STATUS_OK, 2'b01, 8'd0, 1'b0, 11'd0, 3'd0,
				tmram_pkg::HEALTH_STABLE}},
		'{'{tmram_pkg::ACT_INJECT, 5'd0, 5'd0, 10'd6, 1'b0, 2'b00, 8'd0, 16'h8000}, 1'b1,
			OK_RES},
		'{'{tmram_pkg::ACT_READ_PACK, 5'd0, 5'd0, 10'd3, 1'b0, 2'b00, 8'd0, 16'd0}, 1'b0,
			OK_RES},
		'{'{tmram_pkg::ACT_SCRUB, 5'd0, 5'd0, 10'd0, 1'b0, 2'b00, 8'd0, 16'd0}, 1'b0,
			OK_RES},
		'{'{tmram_pkg::ACT_INJECT, 5'd0, 5'd0, 10'd9, 1'b0, 2'b00, 8'd0, 16'd30}, 1'b0,
			OK_RES},
		'{'{tmram_pkg::ACT_STABILIZE, 5'd0, 5'd0, 10'd9, 1'b0, 2'b00, 8'd0, 16'd0}, 1'b0,
			OK_RES},
		'{'{tmram_pkg::ACT_INJECT, 5'd0, 5'd0, 10'd1023, 1'b0, 2'b00, 8'd0, 16'd200}, 1'b0,
			OK_RES},
		'{'{tmram_pkg::ACT_STABILIZE, 5'd0, 5'd0, 10'd0, 1'b1, 2'b00, 8'd0, 16'd0}, 1'b0,
			OK_RES}
	};

	initial begin
		shadow_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		in_pct = 19;
		out_pct = 80;
		foreach (directed[i]) offer(directed[i].req, directed[i].typed, directed[i].res);

		// zero-sized array: every addressed access other than stabilize is out of range
		configure(0, 5, 50, 100, 150, 10, 16);
		random_run(30, 19, 80);
		configure(4, 8, 50, 100, 150, 10, 16);
		random_run(300, 19, 80);
		configure(2, 3, 0, 65535, 65535, 0, 0);
		random_run(250, 80, 19);
		configure(3, 7, 1000, 1200, 3000, 65535, 1024);
		random_run(150, 80, 19);
		// long receiver hold-off so the block backs up into its input
		configure(32, 32, 50, 100, 150, 10, 1024);
		hold_len = 400;
		random_run(120, 0, 0);
		configure(63, 63, 65535, 0, 32768, 5, 3);
		random_run(80, 0, 0);
		configure(8, 5, $urandom_range(0, 300), $urandom_range(300, 600),
			$urandom_range(600, 900), $urandom_range(0, 40), $urandom_range(0, 20));
		random_run(300, 0, 0);

		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d results over eight array settings, %0d scrub failures seen.",
			taken, scrub_fails);
		$display("Requests per action: %p", per_action);
		if (errors == 0) begin
			$display("ternary_mram_array_with_scrub_top verification clean");
		end else begin
			$display("ternary_mram_array_with_scrub_top verification failed");
		end
		$finish;
	end
endmodule
